// ===== design/qph_pkg.sv =====
package qph_pkg;

   // Table geometry (prime slot count)
   localparam int TABLE_SLOTS = 1021;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

   // Fixed field widths of the request and response
   localparam int HOME_W     = 10;
   localparam int OUT_SLOT_W = 10;
   localparam int KEY_W      = 32;
   localparam int DATA_W     = 32;

   // Action codes; the unused code behaves as a find
   localparam logic [1:0] ACT_FIND   = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   typedef enum logic [1:0] {
      MARK_EMPTY   = 2'd0,
      MARK_LIVE    = 2'd1,
      MARK_DELETED = 2'd2
   } mark_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_PRESENT   = 3'd2,
      ST_EXHAUSTED = 3'd3,
      ST_BAD_HOME  = 3'd4
   } status_type;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [1:0]              action;
      logic signed [KEY_W-1:0] key;
      logic [HOME_W-1:0]       home_slot;
      logic [DATA_W-1:0]       insert_data;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [OUT_SLOT_W-1:0] slot;
      logic [DATA_W-1:0]     data_out;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [DATA_W-1:0]       data;
   } entry_type;

   // Command from the sequencer to the slot store
   typedef struct packed {
      logic      rd_en;
      slot_type  rd_addr;
      logic      mark_we;
      logic      entry_we;
      slot_type  wr_addr;
      mark_type  wr_mark;
      entry_type wr_entry;
   } store_cmd_type;

   typedef struct packed {
      mark_type  mark;
      entry_type entry;
   } store_rd_type;

endpackage

// ===== design/qph_step.sv =====
module qph_step (
   input  qph_pkg::slot_type cur,
   input  qph_pkg::slot_type step,
   output qph_pkg::slot_type next_cur,
   output qph_pkg::slot_type next_step
);
   import qph_pkg::*;

   localparam int SUM_W = SLOT_W + 1;

   logic [SUM_W-1:0] cur_sum;
   logic [SUM_W-1:0] step_sum;

   // Advance slot by the step, wrap once
   always_comb begin
      cur_sum = {1'b0, cur} + {1'b0, step};
      if (cur_sum >= SUM_W'(TABLE_SLOTS)) begin
         next_cur = SLOT_W'(cur_sum - SUM_W'(TABLE_SLOTS));
      end else begin
         next_cur = SLOT_W'(cur_sum);
      end
   end

   // Next step is two larger, wrap once
   always_comb begin
      step_sum = {1'b0, step} + SUM_W'(2);
      if (step_sum >= SUM_W'(TABLE_SLOTS)) begin
         next_step = SLOT_W'(step_sum - SUM_W'(TABLE_SLOTS));
      end else begin
         next_step = SLOT_W'(step_sum);
      end
   end

endmodule

// ===== design/qph_store.sv =====
module qph_store (
   input  logic                   clock,
   input  qph_pkg::store_cmd_type cmd,
   output qph_pkg::store_rd_type  rd
);
   import qph_pkg::*;

   mark_type  mark_mem  [TABLE_SLOTS];
   entry_type entry_mem [TABLE_SLOTS];

   mark_type  mark_rd_ff;
   entry_type entry_rd_ff;

   // Write slot marks
   always_ff @(posedge clock) begin
      if (cmd.mark_we) begin
         mark_mem[cmd.wr_addr] <= cmd.wr_mark;
      end
   end

   // Write key and data
   always_ff @(posedge clock) begin
      if (cmd.entry_we) begin
         entry_mem[cmd.wr_addr] <= cmd.wr_entry;
      end
   end

   // Registered read; hold while no read is issued
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         mark_rd_ff  <= mark_mem[cmd.rd_addr];
         entry_rd_ff <= entry_mem[cmd.rd_addr];
      end
   end

   assign rd.mark  = mark_rd_ff;
   assign rd.entry = entry_rd_ff;

endmodule

// ===== design/quadratic_probe_hash_table_top.sv =====
// Open-addressed hash table, quadratic probing with tombstones.
// Request channel (req_valid/req_ready/req_payload): action (find, insert,
// delete), key, home slot from an external hash, and data for inserts.
// Response channel (rsp_valid/rsp_ready/rsp_payload): status, slot where the
// probe ended, and stored data of a found or deleted entry (zero otherwise).
// Each request yields exactly one response, in request order.
// After acceptance the home slot is read; each collision issues the next
// probe, and the response is registered when the probe ends or, for a bad
// home slot, directly. One probe per cycle is set by the single read port of
// the slot store and the single slot/step unit; a request sees at most
// TABLE_SLOTS collisions before it ends as exhausted.
// One request is in flight at a time; req_ready is high only while idle.
// A finished response waits in an output register, so the next request is
// accepted while rsp_valid is pending; a stalled receiver holds the block
// only when the next probe or bad-home response finishes; no table update until then.
// After reset a clearing pass marks every slot empty, one slot per cycle,
// during which req_ready stays low.
module quadratic_probe_hash_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qph_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qph_pkg::rsp_type rsp_payload
);
   import qph_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE,
      S_BAD
   } state_type;

   state_type     state_ff, state_in;
   slot_type      clr_ff, clr_in;
   req_type       req_ff, req_in;
   slot_type      cur_ff, cur_in;
   slot_type      step_ff, step_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   store_cmd_type cmd;
   store_rd_type  rd;
   slot_type      next_cur;
   slot_type      next_step;

   logic          is_insert;
   logic          is_delete;
   logic          key_hit;
   logic          collide;
   logic          rsp_free;
   logic          home_bad;

   qph_step u_step (
      .cur       (cur_ff),
      .step      (step_ff),
      .next_cur  (next_cur),
      .next_step (next_step)
   );

   qph_store u_store (
      .clock (clock),
      .cmd   (cmd),
      .rd    (rd)
   );

   // Decode the latched action
   always_comb begin
      case (req_ff.action)
         ACT_INSERT: begin
            is_insert = 1'b1;
            is_delete = 1'b0;
         end
         ACT_DELETE: begin
            is_insert = 1'b0;
            is_delete = 1'b1;
         end
         ACT_FIND: begin
            is_insert = 1'b0;
            is_delete = 1'b0;
         end
         default: begin
            is_insert = 1'b0;
            is_delete = 1'b0;
         end
      endcase
   end

   // Classify the slot just read
   always_comb begin
      key_hit = (rd.mark == MARK_LIVE) && (rd.entry.key == req_ff.key);
      if (is_insert) begin
         collide = (rd.mark == MARK_LIVE) && !key_hit;
      end else begin
         collide = (rd.mark == MARK_DELETED) || ((rd.mark == MARK_LIVE) && !key_hit);
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign home_bad  = 32'(req_payload.home_slot) >= TABLE_SLOTS;
   assign req_ready = (state_ff == S_IDLE);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      cmd          = '0;
      cmd.wr_mark  = MARK_EMPTY;
      cmd.wr_addr  = cur_ff;
      cmd.rd_addr  = cur_ff;
      cmd.wr_entry = '{key: req_ff.key, data: req_ff.insert_data};

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep marks to empty
            cmd.mark_we = 1'b1;
            cmd.wr_addr = clr_ff;
            if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + SLOT_W'(1);
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in = req_payload;
               if (home_bad) begin
                  state_in = S_BAD;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = SLOT_W'(req_payload.home_slot);
                  cur_in      = SLOT_W'(req_payload.home_slot);
                  step_in     = SLOT_W'(1);
                  cnt_in      = '0;
                  state_in    = S_PROBE;
               end
            end
         end

         S_PROBE: begin
            if (collide && (cnt_ff != CNT_W'(TABLE_SLOTS))) begin
               // Issue the next probe
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = next_cur;
               cur_in      = next_cur;
               step_in     = next_step;
               cnt_in      = cnt_ff + CNT_W'(1);
            end else if (rsp_free) begin
               // Finish: update table and load response
               rsp_valid_in     = 1'b1;
               rsp_in.slot      = OUT_SLOT_W'(cur_ff);
               rsp_in.data_out  = '0;
               state_in         = S_IDLE;
               if (collide) begin
                  rsp_in.status = ST_EXHAUSTED;
               end else if (is_insert) begin
                  if (rd.mark == MARK_LIVE) begin
                     rsp_in.status = ST_PRESENT;
                  end else begin
                     rsp_in.status = ST_DONE;
                     cmd.mark_we   = 1'b1;
                     cmd.entry_we  = 1'b1;
                     cmd.wr_mark   = MARK_LIVE;
                  end
               end else if (rd.mark == MARK_LIVE) begin
                  rsp_in.status   = ST_DONE;
                  rsp_in.data_out = rd.entry.data;
                  if (is_delete) begin
                     cmd.mark_we = 1'b1;
                     cmd.wr_mark = MARK_DELETED;
                  end
               end else begin
                  rsp_in.status = ST_NOT_FOUND;
               end
            end
         end

         S_BAD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_BAD_HOME, slot: '0, data_out: '0};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      cur_ff  <= cur_in;
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Probe position stays inside the table
   a_cur_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> 32'(cur_ff) < TABLE_SLOTS)
      else $error("probe slot out of range");

   // Collision count never passes the table size
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> 32'(cnt_ff) <= TABLE_SLOTS)
      else $error("probe count overrun");

   // Key and data are written only when a probe finishes
   a_entry_we: assert property (@(posedge clock) disable iff (reset)
      cmd.entry_we |-> state_ff == S_PROBE && state_in == S_IDLE && is_insert)
      else $error("entry write outside insert finish");

   // An accepted request starts a probe or a bad-home response
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PROBE || state_ff == S_BAD)
      else $error("accepted request not started");

   // A response appears only out of a probe or bad-home finish
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_PROBE) || $past(state_ff == S_BAD))
      else $error("response from unexpected state");

endmodule
